// ===== sv/base64_codec_unit_assert.svh =====
// Assertion macros shared by the codec's checker.
// Each expects clk and rst_n in scope where it is used.
`ifndef BASE64_CODEC_UNIT_ASSERT_SVH
`define BASE64_CODEC_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define B64C_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64c assertion failed");

// Consequent checked in the cycle after the antecedent.
`define B64C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64c assertion failed");

`endif

// ===== sv/b64c_pkg.sv =====
// Shared types, constants and alphabet functions for the Base64 codec.
// No dependencies; used by every codec module.
package b64c_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // One queued job: up to four results from one accepted item.
  typedef struct packed {
    logic [3:0][7:0] chars;     // result data, chars[0] goes out first
    logic [1:0]      last_idx;  // index of the final result of the job
    logic            dvalid;    // 0 on a bare end marker
    logic            last;      // final result of the job ends the message
    logic            bad;       // sticky error, reported with last
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (w < 8'd26)      c = 8'h41 + w;
    else if (w < 8'd52) c = 8'h61 + (w - 8'd26);
    else if (w < 8'd62) c = 8'h30 + (w - 8'd52);
    else if (w == 8'd62) c = 8'h2B;
    else                c = 8'h2F;
    return c;
  endfunction

  // Returns {ok, value}; ok is 0 for a character outside the alphabet.
  function automatic logic [6:0] dec_val(input logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    ok = 1'b1;
    d  = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A)      d = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) d = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30 + 8'd52;
    else if (c == 8'h2B)               d = 8'd62;
    else if (c == 8'h2F)               d = 8'd63;
    else                               ok = 1'b0;
    return {ok, d[5:0]};
  endfunction

endpackage

// ===== sv/b64c_front.sv =====
// Front end: accepts items, holds the message state and builds at most one job per item.
// Depends on b64c_pkg.
module b64c_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  b64c_pkg::q_stat_t q_stat,
  output logic              push,
  output b64c_pkg::job_t    job
);
  import b64c_pkg::*;

  logic       mode_r,        mode_nxt;
  logic [1:0] group_phase_r, group_phase_nxt;
  logic [5:0] bit_carry_r,   bit_carry_nxt;
  logic [2:0] carry_count_r, carry_count_nxt;
  logic       pad_seen_r,    pad_seen_nxt;
  logic       error_seen_r,  error_seen_nxt;

  logic       accept;
  logic [6:0] dv;
  logic [5:0] v;
  logic       emit;
  logic       err_now;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign dv        = dec_val(in_tdata);
  assign v         = dv[5:0];

  always_comb begin
    mode_nxt        = mode_r;
    group_phase_nxt = group_phase_r;
    bit_carry_nxt   = bit_carry_r;
    carry_count_nxt = carry_count_r;
    pad_seen_nxt    = pad_seen_r;
    error_seen_nxt  = error_seen_r;
    job             = '0;
    job.last        = in_tlast;
    emit            = 1'b0;
    err_now         = error_seen_r;

    if (mode_r == MODE_ENC) begin
      job.dvalid = 1'b1;
      emit       = 1'b1;
      unique case (group_phase_r)
        2'd0: begin
          job.chars[0]    = enc_char(in_tdata[7:2]);
          job.chars[1]    = enc_char({in_tdata[1:0], 4'b0000});
          job.chars[2]    = PAD_CHAR;
          job.chars[3]    = PAD_CHAR;
          job.last_idx    = in_tlast ? 2'd3 : 2'd0;
          bit_carry_nxt   = {4'b0000, in_tdata[1:0]};
          group_phase_nxt = 2'd1;
        end
        2'd1: begin
          job.chars[0]    = enc_char({bit_carry_r[1:0], in_tdata[7:4]});
          job.chars[1]    = enc_char({in_tdata[3:0], 2'b00});
          job.chars[2]    = PAD_CHAR;
          job.last_idx    = in_tlast ? 2'd2 : 2'd0;
          bit_carry_nxt   = {2'b00, in_tdata[3:0]};
          group_phase_nxt = 2'd2;
        end
        default: begin
          job.chars[0]    = enc_char({bit_carry_r[3:0], in_tdata[7:6]});
          job.chars[1]    = enc_char(in_tdata[5:0]);
          job.last_idx    = 2'd1;
          bit_carry_nxt   = '0;
          group_phase_nxt = 2'd0;
        end
      endcase
    end else begin
      if (!pad_seen_r) begin
        if (in_tdata == PAD_CHAR) begin
          pad_seen_nxt = 1'b1;
        end else if (!dv[6]) begin
          err_now = 1'b1;
        end else begin
          unique case (carry_count_r[2:1])
            2'd0: begin
              bit_carry_nxt   = v;
              carry_count_nxt = 3'd6;
            end
            2'd1: begin
              job.chars[0]    = {bit_carry_r[1:0], v};
              emit            = 1'b1;
              bit_carry_nxt   = '0;
              carry_count_nxt = 3'd0;
            end
            2'd2: begin
              job.chars[0]    = {bit_carry_r[3:0], v[5:2]};
              emit            = 1'b1;
              bit_carry_nxt   = {4'b0000, v[1:0]};
              carry_count_nxt = 3'd2;
            end
            default: begin
              job.chars[0]    = {bit_carry_r[5:0], v[5:4]};
              emit            = 1'b1;
              bit_carry_nxt   = {2'b00, v[3:0]};
              carry_count_nxt = 3'd4;
            end
          endcase
        end
      end
      error_seen_nxt = err_now;
      job.dvalid     = emit;
      job.bad        = err_now;
      // a last item with no byte still sends a bare end marker
      emit           = emit || in_tlast;
    end

    if (!accept) begin
      mode_nxt        = mode_r;
      group_phase_nxt = group_phase_r;
      bit_carry_nxt   = bit_carry_r;
      carry_count_nxt = carry_count_r;
      pad_seen_nxt    = pad_seen_r;
      error_seen_nxt  = error_seen_r;
    end else if (in_tlast) begin
      group_phase_nxt = '0;
      bit_carry_nxt   = '0;
      carry_count_nxt = '0;
      pad_seen_nxt    = 1'b0;
      error_seen_nxt  = 1'b0;
    end

    if (cfg_valid) begin
      mode_nxt        = cfg_data;
      group_phase_nxt = '0;
      bit_carry_nxt   = '0;
      carry_count_nxt = '0;
      pad_seen_nxt    = 1'b0;
      error_seen_nxt  = 1'b0;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ENC;
      group_phase_r <= '0;
      bit_carry_r   <= '0;
      carry_count_r <= '0;
      pad_seen_r    <= 1'b0;
      error_seen_r  <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      group_phase_r <= group_phase_nxt;
      bit_carry_r   <= bit_carry_nxt;
      carry_count_r <= carry_count_nxt;
      pad_seen_r    <= pad_seen_nxt;
      error_seen_r  <= error_seen_nxt;
    end
  end

endmodule

// ===== sv/b64c_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on b64c_pkg.
module b64c_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64c_pkg::job_t    wr_job,
  input  logic              pop,
  output b64c_pkg::job_t    head,
  output b64c_pkg::q_stat_t q_stat
);
  import b64c_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;
  logic              do_push, do_pop;

  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ===== sv/b64c_back.sv =====
// Back end: walks the head job one result at a time into the output register.
// Depends on b64c_pkg.
module b64c_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64c_pkg::job_t    head,
  input  b64c_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser
);
  import b64c_pkg::*;

  logic       out_tvalid_r, out_tvalid_nxt;
  logic [1:0] idx_r,        idx_nxt;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;
  logic [1:0] out_tuser_r;
  logic       load;
  logic       at_end;

  assign load   = !q_stat.empty && (!out_tvalid_r || out_tready);
  assign at_end = (idx_r == head.last_idx);
  assign pop    = load && at_end;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    idx_nxt        = idx_r;
    if (load) begin
      out_tvalid_nxt = 1'b1;
      idx_nxt        = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  // tuser: bit 0 data valid, bit 1 bad character (only on the final result)
  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= head.dvalid ? head.chars[idx_r] : 8'h00;
      out_tlast_r <= head.last && at_end;
      out_tuser_r <= {head.last && at_end && head.bad, head.dvalid};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== sv/base64_codec_unit.sv =====
// Base64 codec top level (standard alphabet, '=' padding).
// Depends on b64c_pkg, b64c_front, b64c_queue and b64c_back.
// Usage:
//  - cfg channel: cfg_data is the mode (0 encode, 1 decode). cfg_ready is
//    always high; a transfer sets the mode and clears the message state.
//    Write it only while the block is idle.
//  - in channel: one byte (encode) or character (decode) per transfer,
//    in_tlast marks the last item of a message.
//  - out channel: one character or byte per transfer. out_tlast marks the
//    final result of a message; out_tuser[0] is 0 on a bare end marker
//    (decode end with no byte), out_tuser[1] is the sticky bad-character flag
//    and is only set with out_tlast.
//  - Path: an accepted item is written into the job queue; the back end
//    then loads its first result into the output register.
//  - Throughput: the back end sends one result per cycle while out_tready
//    is high; an item yields up to four results, encode four characters
//    per three bytes and decode three bytes per four characters. The front
//    end takes an item per cycle until the four-job queue fills.
//  - Receiver stall: the output register holds, the queue fills, then
//    in_tready drops. Reset clears mode to encode and empties the queue.
module base64_codec_unit (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,    // mode
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_data
  input  logic       in_tlast,    // in_last
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_data
  output logic       out_tlast,   // out_last
  output logic [1:0] out_tuser    // [0] out_valid, [1] bad_char
);
  import b64c_pkg::*;

  job_t    wr_job;
  job_t    head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  assign cfg_ready = 1'b1;

  b64c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .job       (wr_job)
  );

  b64c_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  b64c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/b64c_checker.sv =====
// Port-level checker for the codec, bound to the top level.
// Depends on base64_codec_unit_assert.svh.
`include "base64_codec_unit_assert.svh"

module b64c_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  // stalled result holds
  `B64C_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // error flag only travels with the final result
  `B64C_ASSERT_NOW(a_bad_on_last, out_tvalid && out_tuser[1], out_tlast)

  // a bare end marker is final and carries zero data
  `B64C_ASSERT_NOW(a_bare_marker, out_tvalid && !out_tuser[0], out_tlast && out_tdata == 8'h00)

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (.*);
